// ===== rtl/pbl_pkg.sv =====
// Package for the page buffer pool frame table: constants, codes and payload types.
// Used by pbl_ctrl, pbl_dpath and page_buffer_pool_lru_unit.
package pbl_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int FRAME_BITS = $clog2(NUM_FRAMES);
  localparam int PAGE_BITS  = 24;
  localparam int CNT_BITS   = $clog2(NUM_FRAMES + 1);

  localparam logic [2:0] CMD_PIN   = 3'd0;
  localparam logic [2:0] CMD_UNPIN = 3'd1;
  localparam logic [2:0] CMD_DIRTY = 3'd2;
  localparam logic [2:0] CMD_FORCE = 3'd3;
  localparam logic [2:0] CMD_FLUSH = 3'd4;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PINNED  = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [23:0] page_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  request_kind;
    logic [3:0]  frame_index;
    logic [23:0] request_page;
    logic [1:0]  status;
    logic        hit;
    logic [31:0] read_count;
    logic [31:0] write_count;
    logic        last;
  } out_item_t;

  // Controller to datapath commands
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,   // latch request, clear scan results
    OP_SCAN,   // examine frame at scan index
    OP_FLUSH,  // examine frame for flush, write back when dirty and unpinned
    OP_FINISH, // apply the command after a full scan, build result
    OP_VICTIM  // after write-back of victim, build read result
  } dp_op_t;

  typedef struct packed {
    dp_op_t                op;
    logic [FRAME_BITS-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] nframes; // active frame count
    logic [2:0]          command;
    logic                two_out; // finish produced a write-back with a read to follow
    logic                flush_emit;
    logic                any_flush;
  } dp_stat_t;

endpackage

// ===== rtl/pbl_dpath.sv =====
// Datapath of the frame table: frame registers, scan results, counters, result register.
// Depends on pbl_pkg.
module pbl_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  input  pbl_pkg::in_item_t req,
  input  pbl_pkg::dp_cmd_t  cmd,
  output pbl_pkg::dp_stat_t stat,
  output pbl_pkg::out_item_t res
);
  import pbl_pkg::*;

  logic [PAGE_BITS-1:0] page_r [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid_r, dirty_r;
  logic [7:0]  fix_r [NUM_FRAMES];
  logic [31:0] age_r [NUM_FRAMES];
  logic [31:0] stamp_r, reads_r, writes_r;
  logic [4:0]  fiu_r;

  in_item_t req_r;
  // scan results
  logic                  fnd_r, unp_r, any_r, emp_r, vic_r, anyf_r;
  logic [FRAME_BITS-1:0] fidx_r, uidx_r, eidx_r, vidx_r;
  logic [FRAME_BITS-1:0] lidx_r; // highest frame that flush will write back
  logic [31:0]           best_r;
  logic                  two_r, femit_r;
  out_item_t             res_r;

  logic [CNT_BITS-1:0] nf;
  logic [FRAME_BITS-1:0] i;
  logic match;

  always_comb begin
    if (fiu_r == 5'd0) nf = CNT_BITS'(1);
    else if (32'(fiu_r) > NUM_FRAMES) nf = CNT_BITS'(NUM_FRAMES);
    else nf = CNT_BITS'(fiu_r);
  end

  assign i = cmd.idx;
  assign match = valid_r[i] && page_r[i] == req_r.page_number;
  assign stat = '{nframes: nf, command: req_r.command, two_out: two_r,
                  flush_emit: femit_r, any_flush: anyf_r};
  assign res = res_r;

  // Build one result item
  function automatic out_item_t mk(logic [1:0] k, logic [FRAME_BITS-1:0] f,
                                   logic [23:0] p, logic [1:0] s, logic h,
                                   logic [31:0] rc, logic [31:0] wc, logic l);
    out_item_t o;
    o.request_kind = k; o.frame_index = 4'(f); o.request_page = p;
    o.status = s; o.hit = h; o.read_count = rc; o.write_count = wc; o.last = l;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0; dirty_r <= '0;
      stamp_r <= '0; reads_r <= '0; writes_r <= '0; fiu_r <= 5'd16;
      for (int k = 0; k < NUM_FRAMES; k++) begin
        page_r[k] <= '0; fix_r[k] <= '0; age_r[k] <= '0;
      end
    end else begin
      if (cfg_we) fiu_r <= cfg_wdata;
      case (cmd.op)
        OP_LOAD: begin
          req_r <= req;
          fnd_r <= 1'b0; unp_r <= 1'b0; any_r <= 1'b0; emp_r <= 1'b0;
          vic_r <= 1'b0; anyf_r <= 1'b0; two_r <= 1'b0; femit_r <= 1'b0;
          if (req.command == CMD_PIN) stamp_r <= stamp_r + 32'd1;
        end
        OP_SCAN: begin
          if (match && !fnd_r) begin fnd_r <= 1'b1; fidx_r <= i; end
          if (match) any_r <= 1'b1;
          if (match && fix_r[i] != 8'd0 && !unp_r) begin unp_r <= 1'b1; uidx_r <= i; end
          if (!valid_r[i] && !emp_r) begin emp_r <= 1'b1; eidx_r <= i; end
          if (fix_r[i] == 8'd0 && (!vic_r || age_r[i] < best_r)) begin
            vic_r <= 1'b1; best_r <= age_r[i]; vidx_r <= i;
          end
          if (valid_r[i] && dirty_r[i] && fix_r[i] == 8'd0) lidx_r <= i;
        end
        OP_FLUSH: begin
          femit_r <= 1'b0;
          if (valid_r[i] && dirty_r[i] && fix_r[i] == 8'd0) begin
            dirty_r[i] <= 1'b0;
            writes_r <= writes_r + 32'd1;
            anyf_r <= 1'b1; femit_r <= 1'b1;
            res_r <= mk(KIND_WRITE, i, page_r[i], ST_OK, 1'b0,
                        reads_r, writes_r + 32'd1, i == lidx_r);
          end
        end
        OP_FINISH: begin
          two_r <= 1'b0;
          case (req_r.command)
            CMD_PIN: begin
              if (fnd_r) begin
                if (fix_r[fidx_r] != 8'hFF) fix_r[fidx_r] <= fix_r[fidx_r] + 8'd1;
                age_r[fidx_r] <= stamp_r;
                res_r <= mk(KIND_ACK, fidx_r, req_r.page_number, ST_OK, 1'b1,
                            reads_r, writes_r, 1'b1);
              end else if (emp_r) begin
                valid_r[eidx_r] <= 1'b1; page_r[eidx_r] <= req_r.page_number;
                dirty_r[eidx_r] <= 1'b0; fix_r[eidx_r] <= 8'd1;
                age_r[eidx_r] <= stamp_r; reads_r <= reads_r + 32'd1;
                res_r <= mk(KIND_READ, eidx_r, req_r.page_number, ST_OK, 1'b0,
                            reads_r + 32'd1, writes_r, 1'b1);
              end else if (!vic_r) begin
                res_r <= mk(KIND_ACK, '0, req_r.page_number, ST_PINNED, 1'b0,
                            reads_r, writes_r, 1'b1);
              end else if (dirty_r[vidx_r]) begin
                writes_r <= writes_r + 32'd1; two_r <= 1'b1;
                res_r <= mk(KIND_WRITE, vidx_r, page_r[vidx_r], ST_OK, 1'b0,
                            reads_r, writes_r + 32'd1, 1'b0);
              end else begin
                page_r[vidx_r] <= req_r.page_number; fix_r[vidx_r] <= 8'd1;
                age_r[vidx_r] <= stamp_r; reads_r <= reads_r + 32'd1;
                res_r <= mk(KIND_READ, vidx_r, req_r.page_number, ST_OK, 1'b0,
                            reads_r + 32'd1, writes_r, 1'b1);
              end
            end
            CMD_UNPIN: begin
              if (unp_r) begin
                fix_r[uidx_r] <= fix_r[uidx_r] - 8'd1;
                res_r <= mk(KIND_ACK, uidx_r, req_r.page_number, ST_OK, 1'b0,
                            reads_r, writes_r, 1'b1);
              end else
                res_r <= mk(KIND_ACK, '0, req_r.page_number,
                            any_r ? ST_OK : ST_MISSING, 1'b0, reads_r, writes_r, 1'b1);
            end
            CMD_DIRTY, CMD_FORCE: begin
              if (!fnd_r)
                res_r <= mk(KIND_ACK, '0, req_r.page_number, ST_MISSING, 1'b0,
                            reads_r, writes_r, 1'b1);
              else if (req_r.command == CMD_DIRTY) begin
                dirty_r[fidx_r] <= 1'b1;
                res_r <= mk(KIND_ACK, fidx_r, req_r.page_number, ST_OK, 1'b0,
                            reads_r, writes_r, 1'b1);
              end else if (dirty_r[fidx_r]) begin
                dirty_r[fidx_r] <= 1'b0; writes_r <= writes_r + 32'd1;
                res_r <= mk(KIND_WRITE, fidx_r, page_r[fidx_r], ST_OK, 1'b0,
                            reads_r, writes_r + 32'd1, 1'b1);
              end else
                res_r <= mk(KIND_ACK, fidx_r, req_r.page_number, ST_OK, 1'b0,
                            reads_r, writes_r, 1'b1);
            end
            default:
              res_r <= mk(KIND_ACK, '0, req_r.page_number, ST_OK, 1'b0,
                          reads_r, writes_r, 1'b1);
          endcase
        end
        OP_VICTIM: begin
          two_r <= 1'b0;
          page_r[vidx_r] <= req_r.page_number; dirty_r[vidx_r] <= 1'b0;
          fix_r[vidx_r] <= 8'd1; age_r[vidx_r] <= stamp_r;
          reads_r <= reads_r + 32'd1;
          res_r <= mk(KIND_READ, vidx_r, req_r.page_number, ST_OK, 1'b0,
                      reads_r + 32'd1, writes_r, 1'b1);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/pbl_ctrl.sv =====
// Controller of the frame table: sequences load, frame scan, finish and result transfers.
// Depends on pbl_pkg.
module pbl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pbl_pkg::dp_stat_t stat,
  output pbl_pkg::dp_cmd_t  cmd
);
  import pbl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SCAN, S_FIN, S_OUT, S_FLUSH, S_FOUT, S_TAIL
  } state_t;

  state_t state_r, state_nxt;
  logic [FRAME_BITS-1:0] idx_r, idx_nxt;
  logic ov_r, ov_nxt;
  logic ml_r, ml_nxt;
  logic [CNT_BITS-1:0] idx_ext;
  logic idx_end;

  assign idx_ext = CNT_BITS'(idx_r) + CNT_BITS'(1);
  assign idx_end = idx_ext >= stat.nframes;
  assign in_ready = state_r == S_IDLE;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; ov_nxt = ov_r; ml_nxt = ml_r;
    cmd.op = OP_NONE; cmd.idx = idx_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op = OP_LOAD; idx_nxt = '0; state_nxt = S_LOAD;
      end
      S_LOAD: state_nxt = S_SCAN;
      // Walk active frames one per cycle; flush uses it to find its final write-back
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (idx_end) state_nxt = S_FIN;
        else idx_nxt = idx_r + FRAME_BITS'(1);
      end
      S_FIN: begin
        if (stat.command == CMD_FLUSH) begin
          idx_nxt = '0; state_nxt = S_FLUSH;
        end else begin
          cmd.op = OP_FINISH; ov_nxt = 1'b1; ml_nxt = 1'b0; state_nxt = S_OUT;
        end
      end
      S_OUT: if (out_ready) begin
        ov_nxt = 1'b0;
        if (stat.two_out) begin
          cmd.op = OP_VICTIM; ov_nxt = 1'b1;
        end else state_nxt = S_IDLE;
      end
      // Flush: visit frames one at a time through S_FLUSH and S_FOUT, hold on each write-back until transferred
      S_FLUSH: begin
        cmd.op = OP_FLUSH; state_nxt = S_FOUT;
        ml_nxt = idx_end;
      end
      S_FOUT: begin
        if (stat.flush_emit) begin
          ov_nxt = 1'b1;
          if (out_valid && out_ready) begin
            ov_nxt = 1'b0;
            if (ml_r) state_nxt = S_IDLE;
            else begin idx_nxt = idx_r + FRAME_BITS'(1); state_nxt = S_FLUSH; end
          end
        end else if (ml_r) begin
          if (stat.any_flush) state_nxt = S_IDLE;
          else begin cmd.op = OP_FINISH; ov_nxt = 1'b1; ml_nxt = 1'b0; state_nxt = S_OUT; end
        end else begin
          idx_nxt = idx_r + FRAME_BITS'(1); state_nxt = S_FLUSH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; idx_r <= '0; ov_r <= 1'b0; ml_r <= 1'b0;
    end else begin
      state_r <= state_nxt; idx_r <= idx_nxt; ov_r <= ov_nxt; ml_r <= ml_nxt;
    end
  end

endmodule

// ===== rtl/page_buffer_pool_lru_unit.sv =====
// Top level of the page buffer pool frame table with LRU replacement.
// Depends on pbl_pkg, pbl_ctrl and pbl_dpath.
//
// Requests enter on in_valid/in_ready with in_data (command, page number).
// Results leave on out_valid/out_ready as out_data; last marks the final
// result of a request. cfg_we with cfg_wdata sets the active frame count.
// A request is taken only when the previous one is fully delivered.
// Pin, unpin, mark dirty and force scan the active frames one per cycle,
// then the result is built and made valid; the active frame count is 16
// at reset; a dirty victim adds a write-back result before the read.
// Flush first scans the active frames to find its final write-back, then
// visits them one at a time, holding on each write-back until transferred.
// The serial frame scan sets the request rate.
// A stalled receiver holds the result and blocks the next request.
// Reset empties all frames, clears counters and sets the frame count to 16.
module page_buffer_pool_lru_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pbl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pbl_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata
);
  import pbl_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_item_t res;

  pbl_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd
  );

  pbl_dpath u_dpath (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .req(in_data), .cmd, .stat, .res
  );

  assign out_data = res;

endmodule

// ===== dv/tb_page_buffer_pool_lru_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for page_buffer_pool_lru_unit: a frame-table predictor in a
// scoreboard class checks every result transfer. Depends on pbl_pkg and the RTL.
module tb_page_buffer_pool_lru_unit;
  import pbl_pkg::*;

  // Frame-table predictor and queue of expected result items
  class pool_scoreboard;
    logic [23:0] fr_page [16];
    bit          fr_valid [16];
    bit          fr_dirty [16];
    logic [7:0]  fr_fix [16];
    logic [31:0] fr_age [16];
    logic [31:0] stamp, reads, writes;
    logic [4:0]  nframes_reg;
    out_item_t   pending_results[$];
    int          errors;
    int          checked;

    function new();
      foreach (fr_page[i]) begin
        fr_page[i] = '0; fr_valid[i] = 0; fr_dirty[i] = 0; fr_fix[i] = '0; fr_age[i] = '0;
      end
      stamp = '0; reads = '0; writes = '0; nframes_reg = 5'd16; errors = 0; checked = 0;
    endfunction

    function int active_count();
      if (nframes_reg == 0) return 1;
      if (nframes_reg > 16) return 16;
      return nframes_reg;
    endfunction

    function int lookup(logic [23:0] pg);
      for (int i = 0; i < active_count(); i++)
        if (fr_valid[i] && fr_page[i] == pg) return i;
      return -1;
    endfunction

    function void push(logic [1:0] kind, int frame, logic [23:0] pg, logic [1:0] st,
                       bit hit, bit last);
      out_item_t r;
      r.request_kind = kind; r.frame_index = frame[3:0]; r.request_page = pg;
      r.status = st; r.hit = hit; r.read_count = reads; r.write_count = writes;
      r.last = last;
      pending_results.push_back(r);
    endfunction

    function void pin(logic [23:0] pg);
      int f, n, v;
      bit found;
      logic [31:0] best;
      n = active_count(); found = 0; best = '0; v = 0;
      stamp++;
      f = lookup(pg);
      if (f >= 0) begin
        if (fr_fix[f] != 8'hff) fr_fix[f]++;
        fr_age[f] = stamp;
        push(KIND_ACK, f, pg, ST_OK, 1, 1);
        return;
      end
      for (int i = 0; i < n; i++) begin
        if (!fr_valid[i]) begin
          fr_valid[i] = 1; fr_page[i] = pg; fr_dirty[i] = 0; fr_fix[i] = 1;
          fr_age[i] = stamp; reads++;
          push(KIND_READ, i, pg, ST_OK, 0, 1);
          return;
        end
      end
      for (int i = 0; i < n; i++)
        if (fr_fix[i] == 0 && (!found || fr_age[i] < best)) begin
          found = 1; best = fr_age[i]; v = i;
        end
      if (!found) begin
        push(KIND_ACK, 0, pg, ST_PINNED, 0, 1);
        return;
      end
      if (fr_dirty[v]) begin
        writes++;
        push(KIND_WRITE, v, fr_page[v], ST_OK, 0, 0);
      end
      fr_page[v] = pg; fr_dirty[v] = 0; fr_fix[v] = 1; fr_age[v] = stamp; reads++;
      push(KIND_READ, v, pg, ST_OK, 0, 1);
    endfunction

    // Predict the results of one accepted request
    function void note_request(in_item_t req);
      int f, n, k;
      bit any;
      logic [23:0] pg;
      pg = req.page_number; n = active_count(); any = 0; k = 0;
      case (req.command)
        CMD_PIN: pin(pg);
        CMD_UNPIN: begin
          for (int i = 0; i < n; i++)
            if (fr_valid[i] && fr_page[i] == pg) begin
              any = 1;
              if (fr_fix[i] > 0) begin
                fr_fix[i]--;
                push(KIND_ACK, i, pg, ST_OK, 0, 1);
                return;
              end
            end
          push(KIND_ACK, 0, pg, any ? ST_OK : ST_MISSING, 0, 1);
        end
        CMD_DIRTY: begin
          f = lookup(pg);
          if (f < 0) push(KIND_ACK, 0, pg, ST_MISSING, 0, 1);
          else begin
            fr_dirty[f] = 1;
            push(KIND_ACK, f, pg, ST_OK, 0, 1);
          end
        end
        CMD_FORCE: begin
          f = lookup(pg);
          if (f < 0) push(KIND_ACK, 0, pg, ST_MISSING, 0, 1);
          else if (fr_dirty[f]) begin
            fr_dirty[f] = 0; writes++;
            push(KIND_WRITE, f, fr_page[f], ST_OK, 0, 1);
          end else push(KIND_ACK, f, pg, ST_OK, 0, 1);
        end
        CMD_FLUSH: begin
          for (int i = 0; i < n && k < 16; i++)
            if (fr_valid[i] && fr_dirty[i] && fr_fix[i] == 0) begin
              fr_dirty[i] = 0; writes++; k++;
              push(KIND_WRITE, i, fr_page[i], ST_OK, 0, 0);
            end
          if (k == 0) push(KIND_ACK, 0, pg, ST_OK, 0, 1);
          else pending_results[$].last = 1;
        end
        default: push(KIND_ACK, 0, pg, ST_OK, 0, 1);
      endcase
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t exp_r;
      checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.request_kind !== exp_r.request_kind) report("request_kind", exp_r.request_kind, got.request_kind);
      if (got.frame_index !== exp_r.frame_index) report("frame_index", exp_r.frame_index, got.frame_index);
      if (got.request_page !== exp_r.request_page) report("request_page", exp_r.request_page, got.request_page);
      if (got.status !== exp_r.status) report("status", exp_r.status, got.status);
      if (got.hit !== exp_r.hit) report("hit", exp_r.hit, got.hit);
      if (got.read_count !== exp_r.read_count) report("read_count", exp_r.read_count, got.read_count);
      if (got.write_count !== exp_r.write_count) report("write_count", exp_r.write_count, got.write_count);
      if (got.last !== exp_r.last) report("last", exp_r.last, got.last);
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      errors++;
      $display("%0t: %s mismatch expected %h actual %h", $time, field, exp_v, act_v);
    endfunction
  endclass

  logic       clk, rst_n;
  logic       in_valid, in_ready, out_valid, out_ready, cfg_we;
  in_item_t   in_data;
  out_item_t  out_data;
  logic [4:0] cfg_wdata;

  pool_scoreboard sb;
  bit         calm;        // no idling while set
  int         hold_cycles; // long receiver hold-off request
  int         sent;
  logic [23:0] hot_pages[8];

  page_buffer_pool_lru_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    out_ready = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      out_ready <= calm || ($urandom_range(99) >= 12);
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Offer one request and wait for its transfer
  task automatic send_request(logic [2:0] cmd, logic [23:0] pg);
    while (!calm && $urandom_range(99) < 12) @(posedge clk);
    in_valid <= 1;
    in_data  <= '{command: cmd, page_number: pg};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request('{command: cmd, page_number: pg});
    sent++;
    in_valid <= 0;
    @(posedge clk);
  endtask

  // Wait until every expected result has come, then let the block settle
  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_frames(logic [4:0] v);
    drain();
    cfg_we <= 1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.nframes_reg = v;
  endtask

  // Mostly pins and unpins on a small page set, so that eviction happens
  task automatic random_burst(int count);
    logic [2:0]  cmd;
    logic [23:0] pg;
    int r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 40) cmd = CMD_PIN;
      else if (r < 65) cmd = CMD_UNPIN;
      else if (r < 80) cmd = CMD_DIRTY;
      else if (r < 88) cmd = CMD_FORCE;
      else if (r < 95) cmd = CMD_FLUSH;
      else cmd = 3'($urandom_range(7));
      if ($urandom_range(9) < 8) pg = hot_pages[$urandom_range(7)];
      else pg = 24'($urandom);
      send_request(cmd, pg);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 0; in_valid = 0; in_data = '0; cfg_we = 0; cfg_wdata = '0;
    calm = 0; hold_cycles = 0; sent = 0;
    foreach (hot_pages[i]) hot_pages[i] = 24'($urandom);
    hot_pages[0] = 24'hffffff; hot_pages[1] = 24'h000000;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: two frames, fill, all pinned, eviction of a dirty victim
    write_frames(5'd2);
    send_request(CMD_UNPIN, 24'h000000);       // not resident
    send_request(CMD_PIN, 24'hffffff);
    send_request(CMD_PIN, 24'h000000);
    send_request(CMD_PIN, 24'hffffff);         // hit
    send_request(CMD_PIN, 24'h123456);         // all pinned
    send_request(CMD_DIRTY, 24'h000000);
    send_request(CMD_FORCE, 24'h000000);       // pinned dirty write-back
    send_request(CMD_FORCE, 24'h000000);       // clean
    send_request(CMD_FORCE, 24'h555555);       // not resident
    send_request(CMD_DIRTY, 24'haaaaaa);       // not resident
    send_request(CMD_DIRTY, 24'h000000);
    send_request(CMD_UNPIN, 24'h000000);
    send_request(CMD_UNPIN, 24'h000000);       // fix count already zero
    send_request(CMD_PIN, 24'h123456);         // dirty victim
    send_request(CMD_FLUSH, 24'h00beef);       // nothing to write
    send_request(3'd5, 24'h0f0f0f);
    send_request(3'd7, 24'hf0f0f0);
    write_frames(5'd0);
    send_request(CMD_PIN, 24'h000001);
    write_frames(5'd31);
    send_request(CMD_DIRTY, 24'hffffff);
    send_request(CMD_UNPIN, 24'hffffff);
    send_request(CMD_UNPIN, 24'hffffff);
    send_request(CMD_FLUSH, 24'h000000);

    // Long receiver hold-off while requests keep coming
    hold_cycles = 300;
    random_burst(10);
    // Sender pause until everything has come back
    drain();

    // Random phases across frame counts, one stretch without idling
    write_frames(5'd16);
    random_burst(40);
    write_frames(5'd1);
    calm = 1;
    random_burst(25);
    calm = 0;
    write_frames(5'd5);
    random_burst(40);
    write_frames(5'd16);
    random_burst(15);

    drain();
    $display("Sent %0d requests, checked %0d results over frame counts 0..31.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
